@@ rtl/shp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH order-2 projection package
// Shared widths, basis constants and the types that pass between the front
// end, the work queue and the back end.
// ----------------------------------------------------------------------------
package shp_pkg;

    // Field widths of the sample and result channels.
    localparam int DIR_W        = 16;
    localparam int WEIGHT_W     = 16;
    localparam int COEF_W       = 40;
    localparam int NCOEF        = 9;
    localparam int COEF_IDX_W   = 4;

    // Default accumulator width; the top level may widen it.
    localparam int ACC_WIDTH_DEF = 40;

    // Polynomial terms are Q.30 and need 33 bits for 3y*y-1 at full scale.
    localparam int POLY_W       = 33;
    // Radiance is unsigned Q1.15 and never exceeds 16 bits.
    localparam int RAD_W        = 16;
    // Basis constants are unsigned Q.20.
    localparam int BASIS_W      = 21;

    // Number of prepared samples held between the front and back ends.
    localparam int QUEUE_DEPTH  = 2;

    // Basis constants for the terms 1, z, y, x, xz, zy, 3yy-1, xy, xx-zz.
    localparam logic [BASIS_W-1:0] BASIS_K [NCOEF] = '{
        21'd295798,  21'd512337,  21'd512337,
        21'd512337,  21'd1145620, 21'd1145620,
        21'd330712,  21'd1145620, 21'd572810
    };

    // One prepared sample: its polynomial terms, radiance and weight.
    typedef struct packed {
        logic [NCOEF-1:0][POLY_W-1:0] poly;
        logic [RAD_W-1:0]             rad;
        logic [WEIGHT_W-1:0]          weight;
        logic                         last;
    } shp_work_t;

    // Queue fill status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } shp_q_status_t;

endpackage

@@ rtl/shp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH projection front end
// Accepts one sample, then works out its radiance and polynomial terms with
// one shared 16x16 multiplier over twelve steps and hands the result to the
// work queue.
// ----------------------------------------------------------------------------
module shp_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [shp_pkg::DIR_W-1:0]     dir_x,
    input  logic signed [shp_pkg::DIR_W-1:0]     dir_y,
    input  logic signed [shp_pkg::DIR_W-1:0]     dir_z,
    input  logic [shp_pkg::WEIGHT_W-1:0]         sample_weight,
    input  logic                                 last_sample,
    input  shp_pkg::shp_q_status_t               q_status,
    output logic                                 push,
    output shp_pkg::shp_work_t                   push_data
);
    import shp_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } fstate_t;

    // Step codes of the calculation sequence.
    localparam logic [3:0] STEP_LIN      = 4'd0;
    localparam logic [3:0] STEP_SQ_FIRST = 4'd1;
    localparam logic [3:0] STEP_SQ_LAST  = 4'd5;
    localparam logic [3:0] STEP_XZ       = 4'd6;
    localparam logic [3:0] STEP_ZY       = 4'd7;
    localparam logic [3:0] STEP_YY       = 4'd8;
    localparam logic [3:0] STEP_XY       = 4'd9;
    localparam logic [3:0] STEP_XX       = 4'd10;
    localparam logic [3:0] STEP_ZZ       = 4'd11;

    // Positions of the polynomial terms.
    localparam int P_ONE  = 0;
    localparam int P_Z    = 1;
    localparam int P_Y    = 2;
    localparam int P_X    = 3;
    localparam int P_XZ   = 4;
    localparam int P_ZY   = 5;
    localparam int P_YY   = 6;
    localparam int P_XY   = 7;
    localparam int P_XXZZ = 8;

    localparam int FRAC_W  = 15;
    localparam int PROD_W  = 2 * DIR_W;
    localparam int P_W     = DIR_W - 1;

    localparam logic [DIR_W-1:0]  LIN_K     = 16'd22938;
    localparam logic [RAD_W-1:0]  RAD_BASE  = 16'd9830;
    localparam logic [PROD_W-1:0] HALF_FRAC = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [POLY_W-1:0] POLY_ONE  = POLY_W'(1) << (2 * FRAC_W);

    fstate_t                    fstate_reg;
    logic [3:0]                 step_reg;
    logic signed [DIR_W-1:0]    x_reg;
    logic signed [DIR_W-1:0]    y_reg;
    logic signed [DIR_W-1:0]    z_reg;
    logic [P_W-1:0]             p_reg;
    shp_work_t                  work_reg;

    logic                       accept;
    logic signed [DIR_W-1:0]    mul_a;
    logic signed [DIR_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_prod;
    logic [PROD_W-1:0]          rnd_sum;
    logic [P_W-1:0]             p_round;
    logic [POLY_W-1:0]          prod_ext;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (fstate_reg != F_IDLE);
    assign push      = (fstate_reg == F_PUSH) && !q_status.full;
    assign push_data = work_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = x_reg;
        mul_b = z_reg;
        if (step_reg == STEP_LIN)
        begin
            mul_a = {1'b0, p_reg};
            mul_b = LIN_K;
        end
        else if (step_reg inside {[STEP_SQ_FIRST:STEP_SQ_LAST]})
        begin
            mul_a = {1'b0, p_reg};
            mul_b = {1'b0, p_reg};
        end
        else
        begin
            case (step_reg)
                STEP_XZ:
                begin
                    mul_a = x_reg;
                    mul_b = z_reg;
                end
                STEP_ZY:
                begin
                    mul_a = z_reg;
                    mul_b = y_reg;
                end
                STEP_YY:
                begin
                    mul_a = y_reg;
                    mul_b = y_reg;
                end
                STEP_XY:
                begin
                    mul_a = x_reg;
                    mul_b = y_reg;
                end
                STEP_XX:
                begin
                    mul_a = x_reg;
                    mul_b = x_reg;
                end
                STEP_ZZ:
                begin
                    mul_a = z_reg;
                    mul_b = z_reg;
                end
                default:
                begin
                    mul_a = x_reg;
                    mul_b = z_reg;
                end
            endcase
        end
    end

    // Product, Q.15 rounding for the radiance steps and sign extension.
    always_comb
    begin
        mul_prod = mul_a * mul_b;
        rnd_sum  = $unsigned(mul_prod) + HALF_FRAC;
        p_round  = rnd_sum[FRAC_W +: P_W];
        prod_ext = {mul_prod[PROD_W-1], mul_prod};
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg <= F_IDLE;
            step_reg   <= STEP_LIN;
        end
        else
        begin
            case (fstate_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        fstate_reg <= F_CALC;
                        step_reg   <= STEP_LIN;
                    end
                end
                F_CALC:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_ZZ)
                    begin
                        fstate_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_status.full)
                    begin
                        fstate_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    fstate_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Sample capture and step results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg                  <= dir_x;
            y_reg                  <= dir_y;
            z_reg                  <= dir_z;
            p_reg                  <= dir_y[DIR_W-1] ? '0 : dir_y[P_W-1:0];
            work_reg.weight        <= sample_weight;
            work_reg.last          <= last_sample;
            work_reg.poly[P_ONE]   <= POLY_ONE;
            work_reg.poly[P_Z]     <= {{(POLY_W-DIR_W-FRAC_W){dir_z[DIR_W-1]}},
                                       dir_z, {FRAC_W{1'b0}}};
            work_reg.poly[P_Y]     <= {{(POLY_W-DIR_W-FRAC_W){dir_y[DIR_W-1]}},
                                       dir_y, {FRAC_W{1'b0}}};
            work_reg.poly[P_X]     <= {{(POLY_W-DIR_W-FRAC_W){dir_x[DIR_W-1]}},
                                       dir_x, {FRAC_W{1'b0}}};
        end
        else if (fstate_reg == F_CALC)
        begin
            if (step_reg == STEP_LIN)
            begin
                work_reg.rad <= RAD_BASE + {1'b0, p_round};
            end
            else if (step_reg inside {[STEP_SQ_FIRST:STEP_SQ_LAST]})
            begin
                p_reg <= p_round;
                if (step_reg == STEP_SQ_LAST)
                begin
                    work_reg.rad <= work_reg.rad + {1'b0, p_round};
                end
            end
            else
            begin
                case (step_reg)
                    STEP_XZ: work_reg.poly[P_XZ] <= prod_ext;
                    STEP_ZY: work_reg.poly[P_ZY] <= prod_ext;
                    STEP_YY: work_reg.poly[P_YY] <= prod_ext
                                                    + {prod_ext[POLY_W-2:0], 1'b0}
                                                    - POLY_ONE;
                    STEP_XY: work_reg.poly[P_XY] <= prod_ext;
                    STEP_XX: work_reg.poly[P_XXZZ] <= prod_ext;
                    STEP_ZZ: work_reg.poly[P_XXZZ] <= work_reg.poly[P_XXZZ] - prod_ext;
                    default: work_reg.poly[P_XXZZ] <= work_reg.poly[P_XXZZ];
                endcase
            end
        end
    end

    // A new sample always starts the sequence at the radiance step.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fstate_reg == F_CALC) && (step_reg == STEP_LIN))
        else $error("front end did not start a new sample at the first step");

endmodule

@@ rtl/shp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH projection work queue
// Short FIFO of prepared samples between the front and back ends. The back
// end works on the head entry in place and releases it when it is done.
// ----------------------------------------------------------------------------
module shp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  shp_pkg::shp_work_t      push_data,
    input  logic                    pop,
    output shp_pkg::shp_q_status_t  status,
    output shp_pkg::shp_work_t      head
);
    import shp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    shp_work_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("sample written into a full work queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("sample released from an empty work queue");

endmodule

@@ rtl/shp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH projection back end
// Takes the head sample of the work queue through the nine basis terms with
// one shared multiplier, four steps per term, adds each weighted term into
// its saturating accumulator and emits the nine sums on a last sample.
// ----------------------------------------------------------------------------
module shp_back #(
    parameter int ACC_WIDTH = shp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  shp_pkg::shp_q_status_t                          q_status,
    input  shp_pkg::shp_work_t                              head,
    output logic                                            pop,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic [shp_pkg::NCOEF-1:0][shp_pkg::COEF_W-1:0]  coef
);
    import shp_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_EMIT
    } bstate_t;

    typedef enum logic [1:0] {
        PH_BASIS,
        PH_RAD,
        PH_WEIGHT,
        PH_ACC
    } phase_t;

    localparam int MUL_A_W  = POLY_W;
    localparam int MUL_B_W  = BASIS_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int B_W      = 32;
    localparam int T_W      = 27;

    localparam int BASIS_SHIFT  = 20;
    localparam int RAD_SHIFT    = 21;
    localparam int WEIGHT_SHIFT = 16;

    localparam logic [PROD_W-1:0] HALF_BASIS  = PROD_W'(1) << (BASIS_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_RAD    = PROD_W'(1) << (RAD_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_WEIGHT = PROD_W'(1) << (WEIGHT_SHIFT - 1);

    localparam logic [COEF_IDX_W-1:0] LAST_COEF = COEF_IDX_W'(NCOEF - 1);

    localparam logic [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [COEF_W-1:0]    COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]    COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    bstate_t                        bstate_reg;
    phase_t                         phase_reg;
    logic [COEF_IDX_W-1:0]          coef_idx_reg;
    logic                           out_valid_reg;
    logic [ACC_WIDTH-1:0]           acc_reg [NCOEF];
    logic signed [B_W-1:0]          b_reg;
    logic signed [T_W-1:0]          t_reg;
    logic signed [T_W-1:0]          term_reg;
    logic [NCOEF-1:0][COEF_W-1:0]   out_coef_reg;

    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       mul_prod;
    logic [PROD_W-1:0]              rnd_basis;
    logic [PROD_W-1:0]              rnd_rad;
    logic [PROD_W-1:0]              rnd_weight;
    logic [ACC_WIDTH:0]             acc_sum;
    logic [ACC_WIDTH-1:0]           acc_new;
    logic [COEF_W-1:0]              sat_val [NCOEF];
    logic                           out_free;
    logic                           load_out;

    assign out_valid = out_valid_reg;
    assign coef      = out_coef_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (bstate_reg == B_EMIT) && head.last && out_free;
    assign pop       = (bstate_reg == B_EMIT) && (!head.last || out_free);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = head.poly[coef_idx_reg];
        mul_b = {1'b0, BASIS_K[coef_idx_reg]};
        case (phase_reg)
            PH_BASIS:
            begin
                mul_a = head.poly[coef_idx_reg];
                mul_b = {1'b0, BASIS_K[coef_idx_reg]};
            end
            PH_RAD:
            begin
                mul_a = {{(MUL_A_W-B_W){b_reg[B_W-1]}}, b_reg};
                mul_b = {{(MUL_B_W-RAD_W){1'b0}}, head.rad};
            end
            PH_WEIGHT:
            begin
                mul_a = {{(MUL_A_W-T_W){t_reg[T_W-1]}}, t_reg};
                mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, head.weight};
            end
            default:
            begin
                mul_a = head.poly[coef_idx_reg];
                mul_b = {1'b0, BASIS_K[coef_idx_reg]};
            end
        endcase
    end

    // Product with round-half-up for each step.
    always_comb
    begin
        mul_prod   = mul_a * mul_b;
        rnd_basis  = $unsigned(mul_prod) + HALF_BASIS;
        rnd_rad    = $unsigned(mul_prod) + HALF_RAD;
        rnd_weight = $unsigned(mul_prod) + HALF_WEIGHT;
    end

    // Saturating accumulate of the current term.
    always_comb
    begin
        acc_sum = {acc_reg[coef_idx_reg][ACC_WIDTH-1], acc_reg[coef_idx_reg]}
                  + {{(ACC_WIDTH+1-T_W){term_reg[T_W-1]}}, term_reg};
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
        begin
            acc_new = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_new = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // Clamp of each sum to the result width.
    for (genvar gi = 0; gi < NCOEF; gi++)
    begin : g_out_sat
        if (ACC_WIDTH > COEF_W)
        begin : g_clamp
            logic [ACC_WIDTH-COEF_W:0] top_bits;
            assign top_bits    = acc_reg[gi][ACC_WIDTH-1:COEF_W-1];
            assign sat_val[gi] = (&top_bits || !(|top_bits))
                               ? acc_reg[gi][COEF_W-1:0]
                               : (acc_reg[gi][ACC_WIDTH-1] ? COEF_MIN : COEF_MAX);
        end
        else if (ACC_WIDTH == COEF_W)
        begin : g_same
            assign sat_val[gi] = acc_reg[gi];
        end
        else
        begin : g_extend
            assign sat_val[gi] = {{(COEF_W-ACC_WIDTH){acc_reg[gi][ACC_WIDTH-1]}},
                                  acc_reg[gi]};
        end
    end

    // Sequencer, accumulators and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= B_IDLE;
            phase_reg     <= PH_BASIS;
            coef_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCOEF; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (bstate_reg)
                B_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        bstate_reg   <= B_CALC;
                        phase_reg    <= PH_BASIS;
                        coef_idx_reg <= '0;
                    end
                end
                B_CALC:
                begin
                    case (phase_reg)
                        PH_BASIS:  phase_reg <= PH_RAD;
                        PH_RAD:    phase_reg <= PH_WEIGHT;
                        PH_WEIGHT: phase_reg <= PH_ACC;
                        PH_ACC:
                        begin
                            acc_reg[coef_idx_reg] <= acc_new;
                            phase_reg             <= PH_BASIS;
                            if (coef_idx_reg == LAST_COEF)
                            begin
                                bstate_reg <= B_EMIT;
                            end
                            else
                            begin
                                coef_idx_reg <= coef_idx_reg + COEF_IDX_W'(1);
                            end
                        end
                        default: phase_reg <= PH_BASIS;
                    endcase
                end
                B_EMIT:
                begin
                    if (pop)
                    begin
                        bstate_reg <= B_IDLE;
                    end
                    if (load_out)
                    begin
                        for (int i = 0; i < NCOEF; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                    end
                end
                default:
                begin
                    bstate_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Intermediate products and the result register.
    always_ff @(posedge clk)
    begin
        if (bstate_reg == B_CALC)
        begin
            case (phase_reg)
                PH_BASIS:  b_reg    <= rnd_basis[BASIS_SHIFT +: B_W];
                PH_RAD:    t_reg    <= rnd_rad[RAD_SHIFT +: T_W];
                PH_WEIGHT: term_reg <= rnd_weight[WEIGHT_SHIFT +: T_W];
                default:   term_reg <= term_reg;
            endcase
        end
        if (load_out)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                out_coef_reg[i] <= sat_val[i];
            end
        end
    end

    // Emitting a result always leaves the sums cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (acc_reg[0] == '0) && (acc_reg[NCOEF-1] == '0))
        else $error("accumulators not cleared after a result was emitted");

    // After each accumulate the next term starts from its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bstate_reg == B_CALC) && (phase_reg == PH_ACC) && (coef_idx_reg != LAST_COEF)
        |=> (phase_reg == PH_BASIS) && (coef_idx_reg == $past(coef_idx_reg) + 1'b1))
        else $error("basis term sequence skipped or repeated a term");

endmodule

@@ rtl/sh_order2_radiance_projection_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH order-2 radiance projection unit
// Projects weighted direction samples of a demo sky radiance onto the nine
// real spherical-harmonic basis terms of bands 0 to 2.
// ----------------------------------------------------------------------------
// The back end's shared multiplier sets the sample rate, with four steps for
// each of nine terms. The front end takes a new sample only after it has
// handed its previous one to the queue, and a two-entry queue sits between
// them. Reset clears the sequencers, the queue and all nine sums.
module sh_order2_radiance_projection_unit #(
    parameter int ACC_WIDTH = shp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_y,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_z,
    input  logic [shp_pkg::WEIGHT_W-1:0]        sample_weight,
    input  logic                                last_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_0,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_1,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_2,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_3,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_4,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_5,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_6,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_7,
    output logic signed [shp_pkg::COEF_W-1:0]   coef_8
);
    import shp_pkg::*;

    shp_q_status_t                  q_status;
    shp_work_t                      push_data;
    shp_work_t                      head;
    logic                           push;
    logic                           pop;
    logic [NCOEF-1:0][COEF_W-1:0]   coef_arr;

    // Sample intake and preparation.
    shp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .sample_weight (sample_weight),
        .last_sample   (last_sample),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    // Prepared samples waiting for the back end.
    shp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    // Basis evaluation and accumulation.
    shp_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .coef      (coef_arr)
    );

    // Result fields.
    assign coef_0 = coef_arr[0];
    assign coef_1 = coef_arr[1];
    assign coef_2 = coef_arr[2];
    assign coef_3 = coef_arr[3];
    assign coef_4 = coef_arr[4];
    assign coef_5 = coef_arr[5];
    assign coef_6 = coef_arr[6];
    assign coef_7 = coef_arr[7];
    assign coef_8 = coef_arr[8];

endmodule

@@ tb/sh_order2_projection_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH order-2 projection checker
// Watches the sample and coefficient channels of the projection unit. Every
// sample transfer is folded into a private copy of the nine sums. A last
// sample closes the set and queues the coefficients that the unit must emit.
// Each coefficient transfer is compared field by field with the oldest
// queued set.
// ----------------------------------------------------------------------------
module sh_order2_projection_checker #(
    parameter int ACC_WIDTH = shp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_y,
    input  logic signed [shp_pkg::DIR_W-1:0]    dir_z,
    input  logic [shp_pkg::WEIGHT_W-1:0]        sample_weight,
    input  logic                                last_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_0,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_1,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_2,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_3,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_4,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_5,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_6,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_7,
    input  logic signed [shp_pkg::COEF_W-1:0]   coef_8,
    output int                                  fail_count,
    output int                                  outstanding
);

    localparam int NCOEF  = shp_pkg::NCOEF;
    localparam int COEF_W = shp_pkg::COEF_W;

    // Term order on the coefficient ports.
    localparam int TERM_ONE  = 0;
    localparam int TERM_Z    = 1;
    localparam int TERM_Y    = 2;
    localparam int TERM_X    = 3;
    localparam int TERM_XZ   = 4;
    localparam int TERM_ZY   = 5;
    localparam int TERM_3YY1 = 6;
    localparam int TERM_XY   = 7;
    localparam int TERM_XXZZ = 8;

    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_set_t;

    // Running sums of the open sample set and the sets awaiting output.
    longint    coef_acc [NCOEF];
    coef_set_t expected_sets [$];

    // Basis normalization constants in unsigned Q.20.
    function automatic longint basis_scale(int term);
        case (term)
            TERM_ONE:                     return 64'sd295798;
            TERM_Z, TERM_Y, TERM_X:       return 64'sd512337;
            TERM_XZ, TERM_ZY, TERM_XY:    return 64'sd1145620;
            TERM_3YY1:                    return 64'sd330712;
            default:                      return 64'sd572810;
        endcase
    endfunction

    // Round half up, then drop the fraction bits.
    function automatic longint round_down_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Sky radiance 0.3 + 0.7*max(0,y) + max(0,y)^32 in unsigned Q1.15.
    function automatic longint sky_radiance(longint y);
        longint yp;
        longint pw;
        int     k;
        yp = (y > 0) ? y : 64'sd0;
        pw = yp;
        for (k = 0; k < 5; k++)
            pw = (pw * pw + 64'sd16384) >>> 15;
        return 64'sd9830 + ((64'sd22938 * yp + 64'sd16384) >>> 15) + pw;
    endfunction

    // Saturating add at the accumulator width.
    function automatic longint add_saturated(longint acc, longint term);
        longint hi;
        longint lo;
        hi = longint'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
        lo = -hi - 64'sd1;
        if (term > 0 && acc > hi - term)
            return hi;
        else if (term < 0 && acc < lo - term)
            return lo;
        else
            return acc + term;
    endfunction

    // Clamp a sum to the output range and take its bits.
    function automatic logic [COEF_W-1:0] clamp_coef(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (COEF_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[COEF_W-1:0];
    endfunction

    // One line per mismatch; the count goes to the top.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR: %s", $time, msg);
        fail_count++;
    endtask

    // Fold one accepted sample into the sums and close the set on a last sample.
    task automatic project_sample();
        longint    x;
        longint    y;
        longint    z;
        longint    w;
        longint    rad;
        longint    basis;
        longint    term;
        longint    poly [NCOEF];
        coef_set_t closed;
        int        k;
        x = longint'(dir_x);
        y = longint'(dir_y);
        z = longint'(dir_z);
        w = longint'({1'b0, sample_weight});
        rad = sky_radiance(y);

        poly[TERM_ONE]  = 64'sd1 <<< 30;
        poly[TERM_Z]    = z * 64'sd32768;
        poly[TERM_Y]    = y * 64'sd32768;
        poly[TERM_X]    = x * 64'sd32768;
        poly[TERM_XZ]   = x * z;
        poly[TERM_ZY]   = z * y;
        poly[TERM_3YY1] = 64'sd3 * y * y - (64'sd1 <<< 30);
        poly[TERM_XY]   = x * y;
        poly[TERM_XXZZ] = x * x - z * z;

        for (k = 0; k < NCOEF; k++) begin
            basis = round_down_shift(basis_scale(k) * poly[k], 20);
            term = round_down_shift(basis * rad, 21);
            term = round_down_shift(term * w, 16);
            coef_acc[k] = add_saturated(coef_acc[k], term);
        end

        if (last_sample) begin
            for (k = 0; k < NCOEF; k++) begin
                closed[k] = clamp_coef(coef_acc[k]);
                coef_acc[k] = 0;
            end
            expected_sets.insert(expected_sets.size(), closed);
        end
    endtask

    // Compare one coefficient transfer with the oldest closed set.
    task automatic check_coefs();
        coef_set_t got;
        coef_set_t want;
        int        k;
        got[TERM_ONE]  = coef_0;
        got[TERM_Z]    = coef_1;
        got[TERM_Y]    = coef_2;
        got[TERM_X]    = coef_3;
        got[TERM_XZ]   = coef_4;
        got[TERM_ZY]   = coef_5;
        got[TERM_3YY1] = coef_6;
        got[TERM_XY]   = coef_7;
        got[TERM_XXZZ] = coef_8;
        if (expected_sets.size() == 0) begin
            report_mismatch("coefficient transfer with no closed sample set");
        end else begin
            want = expected_sets.pop_front();
            for (k = 0; k < NCOEF; k++) begin
                if (got[k] !== want[k])
                    report_mismatch($sformatf("coef_%0d: got %0d, expected %0d",
                        k, $signed(got[k]), $signed(want[k])));
            end
        end
    endtask

    // Both channels are sampled on the same edge the unit uses.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < NCOEF; k++)
                coef_acc[k] = 0;
            expected_sets.delete();
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (out_valid && !out_stall)
                check_coefs();
            if (in_valid && !in_stall)
                project_sample();
            outstanding <= expected_sets.size();
        end
    end

endmodule

@@ tb/sh_order2_radiance_projection_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SH order-2 radiance projection unit testbench
// Drives directed sample sets, one long set of the largest terms, and random
// sets of random length, with random idle cycles on the sample side and
// random stalls on the coefficient side. A separate checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sh_order2_radiance_projection_unit_tb;

    localparam int ACC_W          = shp_pkg::ACC_WIDTH_DEF;
    localparam int DIR_W          = shp_pkg::DIR_W;
    localparam int WEIGHT_W       = shp_pkg::WEIGHT_W;
    localparam int COEF_W         = shp_pkg::COEF_W;
    localparam int RANDOM_SAMPLES = 1430;
    localparam int SATURATE_LEN   = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CYCLE_LIMIT    = 4000000;

    localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7FFF;
    localparam logic signed [DIR_W-1:0] DIR_MIN = 16'sh8000;
    localparam logic [WEIGHT_W-1:0]     W_MAX   = 16'hFFFF;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DIR_W-1:0]    dir_z;
    logic [WEIGHT_W-1:0]        sample_weight;
    logic                       last_sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [COEF_W-1:0]   coef_0;
    logic signed [COEF_W-1:0]   coef_1;
    logic signed [COEF_W-1:0]   coef_2;
    logic signed [COEF_W-1:0]   coef_3;
    logic signed [COEF_W-1:0]   coef_4;
    logic signed [COEF_W-1:0]   coef_5;
    logic signed [COEF_W-1:0]   coef_6;
    logic signed [COEF_W-1:0]   coef_7;
    logic signed [COEF_W-1:0]   coef_8;

    int fail_count;
    int sets_pending;
    int cycle_count;

    sh_order2_radiance_projection_unit #(
        .ACC_WIDTH(ACC_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .sample_weight(sample_weight),
        .last_sample(last_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .coef_0(coef_0),
        .coef_1(coef_1),
        .coef_2(coef_2),
        .coef_3(coef_3),
        .coef_4(coef_4),
        .coef_5(coef_5),
        .coef_6(coef_6),
        .coef_7(coef_7),
        .coef_8(coef_8)
    );

    sh_order2_projection_checker #(
        .ACC_WIDTH(ACC_W)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .sample_weight(sample_weight),
        .last_sample(last_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .coef_0(coef_0),
        .coef_1(coef_1),
        .coef_2(coef_2),
        .coef_3(coef_3),
        .coef_4(coef_4),
        .coef_5(coef_5),
        .coef_6(coef_6),
        .coef_7(coef_7),
        .coef_8(coef_8),
        .fail_count(fail_count),
        .outstanding(sets_pending)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Direction component: corners, values near straight up, or anything.
    function automatic logic [DIR_W-1:0] pick_component();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0:       return DIR_MIN;
                1:       return DIR_MAX;
                2:       return 16'hFFFF;
                3:       return 16'h0001;
                default: return 16'h0000;
            endcase
        end else if (r < 3) begin
            return DIR_W'($urandom_range(28000, 32767));
        end else begin
            return DIR_W'($urandom_range(0, 65535));
        end
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return W_MAX;
        else
            return WEIGHT_W'($urandom_range(0, 65535));
    endfunction

    // Present one sample and hold it until its transfer, then idle if asked.
    task automatic send_sample(input logic signed [DIR_W-1:0] x,
                               input logic signed [DIR_W-1:0] y,
                               input logic signed [DIR_W-1:0] z,
                               input logic [WEIGHT_W-1:0] w,
                               input logic last, input bit idle_on);
        int gap;
        in_valid      <= 1'b1;
        dir_x         <= x;
        dir_y         <= y;
        dir_z         <= z;
        sample_weight <= w;
        last_sample   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sample side until every closed set has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sets_pending != 0)
            @(posedge clk);
    endtask

    // Coefficient side: free stretches, short or long, then stalls of random length.
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                            : $urandom_range(1, 20);
            repeat (n) @(posedge clk);
            out_stall <= 1'b1;
            n = pick_gap() + 1;
            repeat (n) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sh_order2_radiance_projection_unit_tb failed");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int  sent;
        int  set_len;
        int  set_count;
        int  k;
        bit  idle_on;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        dir_x         = '0;
        dir_y         = '0;
        dir_z         = '0;
        sample_weight = '0;
        last_sample   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: zero sample, axis extremes, non-unit corners,
        // multi-sample sets, zero and minimal weights.
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1, 1'b1);
        send_sample(16'sd0, DIR_MAX, 16'sd0, W_MAX, 1'b1, 1'b1);
        send_sample(16'sd0, DIR_MIN, 16'sd0, W_MAX, 1'b1, 1'b1);
        send_sample(DIR_MAX, 16'sd0, 16'sd0, W_MAX, 1'b1, 1'b0);
        send_sample(DIR_MIN, 16'sd0, 16'sd0, W_MAX, 1'b1, 1'b0);
        send_sample(16'sd0, 16'sd0, DIR_MAX, W_MAX, 1'b1, 1'b1);
        send_sample(16'sd0, 16'sd0, DIR_MIN, W_MAX, 1'b1, 1'b1);
        send_sample(DIR_MIN, DIR_MIN, DIR_MIN, W_MAX, 1'b1, 1'b1);
        send_sample(DIR_MAX, DIR_MAX, DIR_MAX, W_MAX, 1'b1, 1'b0);
        send_sample(16'sd23170, 16'sd23170, 16'sd0, W_MAX, 1'b0, 1'b1);
        send_sample(16'sd0, 16'sd23170, -16'sd23170, 16'd1, 1'b1, 1'b1);
        send_sample(16'sd18918, 16'sd18918, 16'sd18918, 16'd32768, 1'b0, 1'b0);
        send_sample(-16'sd18918, -16'sd1, 16'sd1, W_MAX, 1'b0, 1'b1);
        send_sample(16'sd1, 16'sd1, -16'sd1, 16'd12345, 1'b1, 1'b1);
        send_sample(DIR_MAX, 16'sd1, DIR_MIN, 16'd0, 1'b1, 1'b1);
        send_sample(16'sd0, 16'sd16384, 16'sd0, W_MAX, 1'b1, 1'b1);
        wait_for_drain();

        // One long set of the largest terms, back to back, to build large sums.
        for (k = 0; k < SATURATE_LEN; k++)
            send_sample(DIR_MIN, DIR_MAX, DIR_MIN, W_MAX,
                        (k == SATURATE_LEN - 1), 1'b0);
        wait_for_drain();

        // Random sets of random length; some sets start only on an empty unit.
        sent = 0;
        set_count = 0;
        while (sent < RANDOM_SAMPLES) begin
            set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30);
            idle_on = ($urandom_range(0, 3) != 0);
            if (set_count == 10 || $urandom_range(0, 7) == 0)
                wait_for_drain();
            for (k = 0; k < set_len; k++)
                send_sample(pick_component(), pick_component(), pick_component(),
                            pick_weight(), (k == set_len - 1), idle_on);
            sent += set_len;
            set_count++;
        end

        // Let the last sets come out, then give the unit its latency.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("sh_order2_radiance_projection_unit_tb passed");
        else
            $display("sh_order2_radiance_projection_unit_tb failed");
        $finish;
    end

endmodule
